>>> design/drw_pkg.sv
`timescale 1ns / 1ps
// Package: token kinds, slot layout and the token bundle passed between the stages.
package drw_pkg;

    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int WORDS_DEFAULT = 7;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_MODE    = 2'd0;
    localparam t_kind KIND_RELEASE = 2'd1;
    localparam t_kind KIND_ADDR    = 2'd2;
    localparam t_kind KIND_DATA    = 2'd3;

    // Fixed token slots, emitted in slot order. Mode and the opening release never coexist.
    localparam int SLOT_MODE    = 0;
    localparam int SLOT_OPEN    = 1;
    localparam int SLOT_ADDR    = 2;
    localparam int SLOT_DATA_LO = 3;
    localparam int SLOT_DATA_HI = 4;
    localparam int SLOT_CLOSE   = 5;
    localparam int SLOTS        = 6;

    typedef struct packed {
        logic [SLOTS-1:0]  mask;
        logic [BYTE_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_tok_bundle;

    function automatic t_kind slot_kind(input logic [SLOTS-1:0] sel);
        t_kind k;
        k = KIND_RELEASE;
        if (sel[SLOT_MODE]) begin
            k = KIND_MODE;
        end else if (sel[SLOT_ADDR]) begin
            k = KIND_ADDR;
        end else if (sel[SLOT_DATA_LO] || sel[SLOT_DATA_HI]) begin
            k = KIND_DATA;
        end
        return k;
    endfunction

endpackage

>>> design/drw_if.sv
`timescale 1ns / 1ps
// Interfaces: request channel and token channel with valid/ready handshake.
interface drw_in_if;
    import drw_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] overlay;
    logic              frame_end;
    modport source (output valid, output word, output overlay, output frame_end, input ready);
    modport sink   (input valid, input word, input overlay, input frame_end, output ready);
endinterface

interface drw_out_if;
    import drw_pkg::*;
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [BYTE_W-1:0] value;
    logic              run_last;
    modport source (output valid, output kind, output value, output run_last, input ready);
    modport sink   (input valid, input kind, input value, input run_last, output ready);
endinterface

>>> design/drw_diff.sv
`timescale 1ns / 1ps
// Shadow RAM compare: builds the token bundle for one request and advances frame state.
module drw_diff
    import drw_pkg::*;
#(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [WORD_W-1:0] i_word,
    input  logic [WORD_W-1:0] i_overlay,
    input  logic              i_frame_end,
    output t_tok_bundle       o_bundle
);

    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

    logic [WORD_W-1:0] r_shadow [WORDS];
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_last_wr;
    logic              r_any_wr;

    logic [WORD_W-1:0] w_merged;
    logic              w_changed;
    logic              w_adjacent;
    logic              w_end;
    logic              w_any_after;

    always_comb begin
        w_merged    = i_word | i_overlay;
        w_changed   = (w_merged != r_shadow[r_pos]);
        w_adjacent  = r_any_wr && (({1'b0, r_last_wr} + (IDX_W+1)'(1)) == {1'b0, r_pos});
        w_end       = i_frame_end || (r_pos == LAST_IDX);
        w_any_after = r_any_wr || w_changed;

        o_bundle.mask = '0;
        o_bundle.mask[SLOT_MODE]    = w_changed && !r_any_wr;
        o_bundle.mask[SLOT_OPEN]    = w_changed && r_any_wr && !w_adjacent;
        o_bundle.mask[SLOT_ADDR]    = w_changed && !w_adjacent;
        o_bundle.mask[SLOT_DATA_LO] = w_changed;
        o_bundle.mask[SLOT_DATA_HI] = w_changed;
        o_bundle.mask[SLOT_CLOSE]   = w_end && w_any_after;
        o_bundle.addr = BYTE_W'({r_pos, 1'b0});
        o_bundle.data = w_merged;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) begin
                r_shadow[i] <= '0;
            end
            r_pos     <= '0;
            r_last_wr <= '0;
            r_any_wr  <= 1'b0;
        end else if (i_accept) begin
            if (w_changed) begin
                r_shadow[r_pos] <= w_merged;
            end
            if (w_end) begin
                r_pos     <= '0;
                r_last_wr <= '0;
                r_any_wr  <= 1'b0;
            end else begin
                r_pos    <= r_pos + IDX_W'(1);
                r_any_wr <= w_any_after;
                if (w_changed) begin
                    r_last_wr <= r_pos;
                end
            end
        end
    end

endmodule

>>> design/drw_tok_ser.sv
`timescale 1ns / 1ps
// Token serializer: holds one bundle and sends its tokens one per cycle in slot order while i_ready is high.
module drw_tok_ser
    import drw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_tok_bundle       i_bundle,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output t_kind             o_kind,
    output logic [BYTE_W-1:0] o_value,
    output logic              o_run_last
);

    logic [SLOTS-1:0]  r_mask;
    logic [BYTE_W-1:0] r_addr;
    logic [WORD_W-1:0] r_data;
    logic [SLOTS-1:0]  n_mask;
    logic [SLOTS-1:0]  w_sel;
    logic              w_found;
    logic              w_take;

    // Pick the lowest pending slot.
    always_comb begin
        w_sel   = '0;
        w_found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_mask[i] && !w_found) begin
                w_sel[i] = 1'b1;
                w_found  = 1'b1;
            end
        end
    end

    always_comb begin
        o_valid    = |r_mask;
        o_run_last = ((r_mask & ~w_sel) == '0);
        o_kind     = slot_kind(w_sel);
        o_value    = '0;
        if (w_sel[SLOT_ADDR]) begin
            o_value = r_addr;
        end else if (w_sel[SLOT_DATA_LO]) begin
            o_value = r_data[BYTE_W-1:0];
        end else if (w_sel[SLOT_DATA_HI]) begin
            o_value = r_data[WORD_W-1:BYTE_W];
        end
        w_take = o_valid && i_ready;
        o_free = !o_valid || (w_take && o_run_last);
        n_mask = w_take ? (r_mask & ~w_sel) : r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_bundle.mask;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr <= i_bundle.addr;
            r_data <= i_bundle.data;
        end
    end

endmodule

>>> design/display_ram_diff_writer.sv
`timescale 1ns / 1ps
// Top level: display RAM difference writer, shadow compare plus token serializer.
//
//  Channel   Dir  Payload                       Meaning
//  i_req     in   word, overlay, frame_end      one display word per request, index order
//  o_tok     out  kind, value, run_last         write-mode / strobe / address / data tokens
//
// Flow: a request is compared against the shadow RAM in the cycle it is accepted and
// its tokens (0 to 5) land in the bundle register; the serializer then sends one token
// per cycle while o_tok.ready is high. A request with no token leaves it free; one with
// tokens holds off the next request until its last is taken; the token port sets the rate.
// Stalls: a request is taken when the serializer is empty or its last token is accepted.
// Reset: synchronous, clears the shadow RAM, frame position and the pending tokens.
module display_ram_diff_writer
    import drw_pkg::*;
#(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drw_in_if.sink     i_req,
    drw_out_if.source  o_tok
);

    t_tok_bundle w_bundle;
    logic        w_accept;
    logic        w_free;
    logic        w_load;

    // Accept whenever the serializer is empty or just sending its last token.
    assign i_req.ready = w_free;
    assign w_accept    = i_req.valid && w_free;
    // Load only requests that produce tokens; quiet requests just advance state.
    assign w_load      = w_accept && (|w_bundle.mask);

    drw_diff #(
        .WORDS (WORDS)
    ) u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_req.word),
        .i_overlay   (i_req.overlay),
        .i_frame_end (i_req.frame_end),
        .o_bundle    (w_bundle)
    );

    drw_tok_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_bundle   (w_bundle),
        .o_free     (w_free),
        .o_valid    (o_tok.valid),
        .i_ready    (o_tok.ready),
        .o_kind     (o_tok.kind),
        .o_value    (o_tok.value),
        .o_run_last (o_tok.run_last)
    );

`ifndef SYNTHESIS
    // Hold off requests while tokens other than the last are pending.
    a_ready_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.ready && o_tok.valid) |-> (o_tok.ready && o_tok.run_last))
        else $error("request taken while tokens still pending");

    // The write-mode command never ends a request; in the design an address token follows it.
    a_mode_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.kind == KIND_MODE) |-> !o_tok.run_last)
        else $error("write-mode command ended a request");

    // An address token is always followed by data.
    a_addr_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.ready && o_tok.kind == KIND_ADDR) |=>
        (o_tok.valid && o_tok.kind == KIND_DATA))
        else $error("address token not followed by data");

    // Reset drops all pending tokens.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tok.valid)
        else $error("tokens pending after reset");
`endif

endmodule

>>> dv/drw_token_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the display write tokens of each accepted request and compares them.
module drw_token_checker
    import drw_pkg::*;
#(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [WORD_W-1:0] i_word,
    input  logic [WORD_W-1:0] i_overlay,
    input  logic              i_frame_end,
    input  logic              i_tok_valid,
    input  logic              i_tok_ready,
    input  t_kind             i_kind,
    input  logic [BYTE_W-1:0] i_value,
    input  logic              i_run_last,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic              run_last;
    } t_token;

    // Mirror of the display RAM and of the frame bookkeeping.
    logic [WORD_W-1:0] shadow_words [WORDS];
    logic [2:0]        frame_pos;
    logic [2:0]        last_idx;
    logic              wrote_any;
    t_token            token_fifo [$];

    function automatic t_token mk_token(input t_kind k, input logic [BYTE_W-1:0] v);
        t_token t;
        t.kind     = k;
        t.value    = v;
        t.run_last = 1'b0;
        return t;
    endfunction

    // Work out the tokens of one request, advance the mirror state and queue them.
    task automatic queue_diff_tokens(input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] ov,
                                     input logic fe);
        t_token            toks [6];
        int                n;
        logic [WORD_W-1:0] merged;
        logic              adjacent;
        logic              closes;
        n = 0;
        merged = w | ov;
        closes = fe || (int'(frame_pos) + 1 >= WORDS);
        if (merged != shadow_words[frame_pos]) begin
            adjacent = wrote_any && (int'(last_idx) + 1 == int'(frame_pos));
            shadow_words[frame_pos] = merged;
            if (!wrote_any) begin
                toks[n] = mk_token(KIND_MODE, '0);
                n++;
            end else if (!adjacent) begin
                toks[n] = mk_token(KIND_RELEASE, '0);
                n++;
            end
            if (!adjacent) begin
                toks[n] = mk_token(KIND_ADDR, BYTE_W'({frame_pos, 1'b0}));
                n++;
            end
            toks[n] = mk_token(KIND_DATA, merged[7:0]);
            n++;
            toks[n] = mk_token(KIND_DATA, merged[15:8]);
            n++;
            wrote_any = 1'b1;
            last_idx  = frame_pos;
        end
        if (closes) begin
            if (wrote_any) begin
                toks[n] = mk_token(KIND_RELEASE, '0);
                n++;
            end
            frame_pos = '0;
            last_idx  = '0;
            wrote_any = 1'b0;
        end else begin
            frame_pos = frame_pos + 3'd1;
        end
        if (n > 0) begin
            toks[n-1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            token_fifo.push_back(toks[i]);
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: token %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        o_fail_count++;
    endtask

    // Take the request first: its tokens can never leave in the cycle it is accepted.
    always @(posedge i_clk) begin : watch
        t_token want;
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) begin
                shadow_words[i] = '0;
            end
            frame_pos = '0;
            last_idx  = '0;
            wrote_any = 1'b0;
            token_fifo.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                queue_diff_tokens(i_word, i_overlay, i_frame_end);
            end
            if (i_tok_valid && i_tok_ready) begin
                if (token_fifo.size() == 0) begin
                    $display("%0t: unexpected token, expected none, %s %0d value %0h last %0d",
                             $time, "actual kind", i_kind, i_value, i_run_last);
                    o_fail_count++;
                end else begin
                    want = token_fifo.pop_front();
                    if (i_kind !== want.kind) begin
                        report_field("kind", int'(want.kind), int'(i_kind));
                    end
                    if (i_value !== want.value) begin
                        report_field("value", int'(want.value), int'(i_value));
                    end
                    if (i_run_last !== want.run_last) begin
                        report_field("run_last", int'(want.run_last), int'(i_run_last));
                    end
                end
            end
        end
        o_pending = token_fifo.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives display word requests and token backpressure, gives the verdict.
module testbench;
    import drw_pkg::*;

    localparam int ITEM_TARGET  = 150;      // random requests after the directed part
    localparam int CALM_TAIL    = 30;       // last random requests run without idling
    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest correct run
    localparam int DRAIN_CYCLES = 20;       // settle time after the last expected token

    logic i_clk;
    logic i_rst_n;

    drw_in_if  req_if ();
    drw_out_if tok_if ();

    int   fail_count;
    int   pending;
    int   cycle_count;
    logic idle_on;

    // What the display RAM should hold after each sent word; used only to shape stimulus
    // (repeat a word so that it is unchanged, or flip one bit of it).
    logic [WORD_W-1:0] sent_words [WORDS_DEFAULT];
    int                stim_pos;

    display_ram_diff_writer #(.WORDS(WORDS_DEFAULT)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_tok   (tok_if)
    );

    drw_token_checker #(.WORDS(WORDS_DEFAULT)) u_token_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_word       (req_if.word),
        .i_overlay    (req_if.overlay),
        .i_frame_end  (req_if.frame_end),
        .i_tok_valid  (tok_if.valid),
        .i_tok_ready  (tok_if.ready),
        .i_kind       (tok_if.kind),
        .i_value      (tok_if.value),
        .i_run_last   (tok_if.run_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: a hang anywhere counts as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Token sink: hold ready low for random bursts while idling is on,
    // otherwise keep it high. Each edge gets at most one assignment to ready.
    initial begin
        tok_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && i_rst_n && $urandom_range(0, 5) == 0) begin
                tok_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            tok_if.ready <= 1'b1;
        end
    end

    // Send one request: optionally idle first, then hold valid until it is accepted.
    // Returns at the edge of acceptance, so the next call may keep valid high.
    task automatic send_request(input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] ov,
                                input logic fe);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.word      <= w;
        req_if.overlay   <= ov;
        req_if.frame_end <= fe;
        do @(posedge i_clk); while (!req_if.ready);
        sent_words[stim_pos] = w | ov;
        if (fe || stim_pos == WORDS_DEFAULT - 1) begin
            stim_pos = 0;
        end else begin
            stim_pos++;
        end
    endtask

    // Drop valid and wait until every predicted token has come out.
    task automatic drain_tokens();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                sent;
        int                frame_len;
        int                pick;
        logic              no_mark;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] ov;
        logic [WORD_W-1:0] v;

        req_if.valid     = 1'b0;
        req_if.word      = '0;
        req_if.overlay   = '0;
        req_if.frame_end = 1'b0;
        i_rst_n          = 1'b0;
        idle_on          = 1'b1;
        stim_pos         = 0;
        for (int i = 0; i < WORDS_DEFAULT; i++) begin
            sent_words[i] = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full frame without a frame_end mark: the last index closes it by itself.
        // Covers the mode token, gaps (unchanged zero words), adjacent runs and OR merging.
        send_request(16'hffff, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b0);
        send_request(16'h00ff, 16'hff00, 1'b0);
        send_request(16'h1234, 16'h8001, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b0);
        send_request(16'h8000, 16'h0000, 1'b0);
        send_request(16'hffff, 16'hffff, 1'b0);
        // Early frame end with nothing changed: no tokens at all.
        send_request(16'hff00, 16'h00ff, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        // Changes at 0, 1, 2 with the end on the third: one run, closing strobe.
        send_request(16'h0000, 16'h0000, 1'b0);
        send_request(16'h5a5a, 16'h0000, 1'b0);
        send_request(16'h0000, 16'h0000, 1'b1);
        // One-word frame that changes, then one that repeats the word.
        send_request(16'ha5a5, 16'h0000, 1'b1);
        send_request(16'h0005, 16'ha5a0, 1'b1);
        // Full frame marked at the last index, every word rewritten.
        for (int k = 0; k < WORDS_DEFAULT; k++) begin
            send_request(WORD_W'(16'h0101 * (k + 1)), (k % 2) ? 16'hffff : 16'h0000,
                         k == WORDS_DEFAULT - 1);
        end

        // Hold off until the directed tokens are all out.
        drain_tokens();

        // Random frames: mostly well-formed frames of random length with random content,
        // some without a mark so the frame runs to the last index.
        sent = 0;
        while (sent < ITEM_TARGET) begin
            frame_len = $urandom_range(1, WORDS_DEFAULT);
            no_mark   = ($urandom_range(0, 9) == 0);
            if (no_mark) begin
                frame_len = WORDS_DEFAULT;
            end
            for (int k = 0; k < frame_len; k++) begin
                idle_on = (sent < ITEM_TARGET - CALM_TAIL);
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    // Repeat the stored word, or flip one bit of it; split it randomly
                    // between word and overlay so the OR gives the value back.
                    v = sent_words[k];
                    if (pick >= 4) begin
                        v = v ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
                    end
                    ov = v & WORD_W'($urandom);
                    w  = (v & ~ov) | (v & WORD_W'($urandom));
                end else if (pick == 6) begin
                    w  = $urandom_range(0, 1) ? '1 : '0;
                    ov = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    w  = WORD_W'($urandom);
                    ov = ($urandom_range(0, 2) == 0) ? WORD_W'($urandom) : '0;
                end
                send_request(w, ov, !no_mark && (k == frame_len - 1));
                sent++;
            end
        end

        drain_tokens();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/drw_pkg.sv
design/drw_if.sv
design/drw_diff.sv
design/drw_tok_ser.sv
design/display_ram_diff_writer.sv
dv/drw_token_checker.sv
dv/testbench.sv
